// ===== rtl/cstd_pkg.sv =====
// Shared types, register map and constants for the calibrated sound threshold detector.
package cstd_pkg;

	// Field widths.
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W = 8;
	localparam int MULT_W = 8;
	localparam int GAINED_W = SAMPLE_W + GAIN_W;
	localparam int CNT_W = 11;
	localparam int THR_W = 32;
	localparam int AVG_W = 24;
	localparam int SUM_W = 40;
	localparam int PROD_W = AVG_W + MULT_W + 1;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int IDX_W = ADDR_W - 2;

	// The divider retires one quotient bit per step over the whole sum width.
	localparam int DIV_STEPS = SUM_W;
	localparam int ITER_W = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// Input item kinds.
	localparam logic [1:0] KIND_CAL = 2'd0;
	localparam logic [1:0] KIND_FIX = 2'd1;
	localparam logic [1:0] KIND_DET = 2'd2;

	// Result kinds.
	localparam logic RES_THR = 1'b0;
	localparam logic RES_VERDICT = 1'b1;

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_GAIN = 3'd0;
	localparam logic [IDX_W-1:0] REG_MULT = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_THR = 3'd2;
	localparam logic [IDX_W-1:0] REG_CAL_SKIP = 3'd3;
	localparam logic [IDX_W-1:0] REG_DET_SKIP = 3'd4;
	localparam logic [IDX_W-1:0] REG_CNT_LIMIT = 3'd5;

	// Register reset values.
	localparam logic [GAIN_W-1:0] GAIN_RST = 8'd1;
	localparam logic [MULT_W-1:0] MULT_RST = 8'd2;
	localparam logic [THR_W-1:0] MIN_THR_RST = 32'd0;
	localparam logic [CNT_W-1:0] CAL_SKIP_RST = 11'd10;
	localparam logic [CNT_W-1:0] DET_SKIP_RST = 11'd5;
	localparam logic [CNT_W-1:0] CNT_LIMIT_RST = 11'd5;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [MULT_W-1:0] threshold_multiplier;
		logic [THR_W-1:0] min_threshold;
		logic [CNT_W-1:0] calibration_skip;
		logic [CNT_W-1:0] detection_skip;
		logic [CNT_W-1:0] count_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_AVG,
		ST_MUL,
		ST_FIX
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic sample_en;
		logic div_start;
		logic div_step;
		logic avg_en;
		logic mul_en;
		logic fix_en;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic calibrated;
		logic div_last;
	} dp_sts_t;

	typedef struct packed {
		logic result_kind;
		logic above_threshold;
		logic [CNT_W-1:0] loud_count;
		logic [AVG_W-1:0] average_level;
		logic [THR_W-1:0] threshold_value;
	} result_t;

endpackage

// ===== rtl/cstd_if.sv =====
// Valid/ready channel interfaces for audio input items and result items.
interface cstd_audio_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic signed [cstd_pkg::SAMPLE_W-1:0] sample;
	logic last_in_buffer;

	modport source(output valid, kind, sample, last_in_buffer, input ready);
	modport sink(input valid, kind, sample, last_in_buffer, output ready);
endinterface

interface cstd_report_if;
	logic valid;
	logic ready;
	logic result_kind;
	logic above_threshold;
	logic [cstd_pkg::CNT_W-1:0] loud_count;
	logic signed [cstd_pkg::AVG_W-1:0] average_level;
	logic signed [cstd_pkg::THR_W-1:0] threshold_value;

	modport source(output valid, result_kind, above_threshold, loud_count, average_level,
		threshold_value, input ready);
	modport sink(input valid, result_kind, above_threshold, loud_count, average_level,
		threshold_value, output ready);
endinterface

// ===== rtl/cstd_regs.sv =====
// APB configuration register file.
module cstd_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [cstd_pkg::ADDR_W-1:0] paddr,
	input logic [cstd_pkg::DATA_W-1:0] pwdata,
	output logic [cstd_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output cstd_pkg::cfg_t cfg
);
	import cstd_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = paddr[ADDR_W-1:2];
	assign cfg = cfg_q;

	// Register writes complete in the access phase of a transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain <= GAIN_RST;
			cfg_q.threshold_multiplier <= MULT_RST;
			cfg_q.min_threshold <= MIN_THR_RST;
			cfg_q.calibration_skip <= CAL_SKIP_RST;
			cfg_q.detection_skip <= DET_SKIP_RST;
			cfg_q.count_limit <= CNT_LIMIT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_GAIN: cfg_q.gain <= pwdata[GAIN_W-1:0];
				REG_MULT: cfg_q.threshold_multiplier <= pwdata[MULT_W-1:0];
				REG_MIN_THR: cfg_q.min_threshold <= pwdata[THR_W-1:0];
				REG_CAL_SKIP: cfg_q.calibration_skip <= pwdata[CNT_W-1:0];
				REG_DET_SKIP: cfg_q.detection_skip <= pwdata[CNT_W-1:0];
				REG_CNT_LIMIT: cfg_q.count_limit <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data mux; unused addresses read as zero.
	always_comb begin
		unique case (idx)
			REG_GAIN: prdata = DATA_W'(cfg_q.gain);
			REG_MULT: prdata = DATA_W'(cfg_q.threshold_multiplier);
			REG_MIN_THR: prdata = DATA_W'(cfg_q.min_threshold);
			REG_CAL_SKIP: prdata = DATA_W'(cfg_q.calibration_skip);
			REG_DET_SKIP: prdata = DATA_W'(cfg_q.detection_skip);
			REG_CNT_LIMIT: prdata = DATA_W'(cfg_q.count_limit);
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/cstd_ctrl.sv =====
// Controller state machine: sample acceptance and the threshold fixing sequence.
module cstd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] in_kind,
	input logic rq_full,
	input cstd_pkg::dp_sts_t sts,
	output logic in_ready,
	output cstd_pkg::dp_cmd_t cmd
);
	import cstd_pkg::*;

	ctrl_state_t state_q, state_d;
	logic accept;
	logic fix_go;

	assign accept = in_valid && in_ready;
	assign fix_go = accept && (in_kind == KIND_FIX) && !sts.calibrated;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fix_go) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_AVG;
				end
			end
			ST_AVG: state_d = ST_MUL;
			ST_MUL: state_d = ST_FIX;
			ST_FIX: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !rq_full;
				cmd.sample_en = accept && ((in_kind == KIND_CAL) || (in_kind == KIND_DET));
				cmd.div_start = fix_go;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_AVG: cmd.avg_en = 1'b1;
			ST_MUL: cmd.mul_en = 1'b1;
			ST_FIX: cmd.fix_en = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== rtl/cstd_dp.sv =====
// Datapath: buffer tracking, accumulation, loud sample counting, divider and threshold math.
module cstd_dp #(
	parameter int BUFFER_SAMPLES = 1024
) (
	input logic clk,
	input logic arst_n,
	input cstd_pkg::cfg_t cfg,
	input cstd_pkg::dp_cmd_t cmd,
	input logic [1:0] in_kind,
	input logic signed [cstd_pkg::SAMPLE_W-1:0] in_sample,
	input logic in_last,
	output cstd_pkg::dp_sts_t sts,
	output logic push,
	output cstd_pkg::result_t push_data
);
	import cstd_pkg::*;

	localparam int POS_W = $clog2(BUFFER_SAMPLES + 1);
	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	// Buffer and accumulation state.
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] ccnt_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] dcnt_q;
	logic signed [THR_W-1:0] thr_q;
	logic cal_q;

	// Divider and threshold pipeline.
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [ITER_W-1:0] iter_q;
	logic neg_q;
	logic zero_q;
	logic signed [AVG_W-1:0] avg_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [GAINED_W-1:0] gained;
	logic pos_zero;
	logic in_range;
	logic [CMP_W-1:0] pos_w;
	logic is_cal;
	logic is_det;
	logic signed [SUM_W-1:0] sum_base;
	logic signed [SUM_W-1:0] sum_next;
	logic [CNT_W-1:0] ccnt_base;
	logic [CNT_W-1:0] dcnt_base;
	logic [CNT_W-1:0] dcnt_next;
	logic cal_add;
	logic det_inc;
	logic [CNT_W:0] shifted;
	logic [CNT_W:0] diff;
	logic ge;
	logic [AVG_W-1:0] quo_mag;
	logic signed [THR_W-1:0] sat;
	logic signed [THR_W-1:0] thr_new;

	// Per-sample decisions for calibration and detection buffers.
	always_comb begin
		gained = GAINED_W'(in_sample) * GAINED_W'($signed({1'b0, cfg.gain}));
		pos_zero = (pos_q == '0);
		in_range = (pos_q < POS_W'(BUFFER_SAMPLES));
		pos_w = CMP_W'(pos_q);
		is_cal = (in_kind == KIND_CAL);
		is_det = (in_kind == KIND_DET);
		sum_base = pos_zero ? '0 : sum_q;
		ccnt_base = pos_zero ? '0 : ccnt_q;
		dcnt_base = pos_zero ? '0 : dcnt_q;
		cal_add = in_range && (pos_w >= CMP_W'(cfg.calibration_skip)) &&
			(ccnt_base != COUNT_MAX);
		det_inc = in_range && (pos_w >= CMP_W'(cfg.detection_skip)) &&
			(THR_W'(gained) > thr_q) && (dcnt_base != COUNT_MAX);
		sum_next = cal_add ? (sum_base + SUM_W'(gained)) : sum_base;
		dcnt_next = det_inc ? (dcnt_base + CNT_W'(1)) : dcnt_base;
	end

	// One restoring divider step, then saturation and clamp of the product.
	always_comb begin
		shifted = {rem_q, quo_q[SUM_W-1]};
		ge = (shifted >= {1'b0, ccnt_q});
		diff = shifted - {1'b0, ccnt_q};
		quo_mag = quo_q[AVG_W-1:0];
		if (prod_q[PROD_W-1] != prod_q[PROD_W-2]) begin
			sat = prod_q[PROD_W-1] ? {1'b1, {(THR_W-1){1'b0}}} : {1'b0, {(THR_W-1){1'b1}}};
		end else begin
			sat = prod_q[THR_W-1:0];
		end
		thr_new = (sat < $signed(cfg.min_threshold)) ? $signed(cfg.min_threshold) : sat;
	end

	// Buffer state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ccnt_q <= '0;
			pos_q <= '0;
			dcnt_q <= '0;
			thr_q <= '0;
			cal_q <= 1'b0;
		end else begin
			if (cmd.sample_en) begin
				if (is_cal) begin
					sum_q <= sum_next;
					ccnt_q <= cal_add ? (ccnt_base + CNT_W'(1)) : ccnt_base;
					if (pos_zero) begin
						cal_q <= 1'b0;
					end
				end
				if (is_det) begin
					dcnt_q <= dcnt_next;
				end
				if (in_last) begin
					pos_q <= '0;
				end else if (in_range) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			if (cmd.fix_en) begin
				thr_q <= thr_new;
				cal_q <= 1'b1;
			end
		end
	end

	// Divider, average and product registers.
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q;
			rem_q <= '0;
			iter_q <= '0;
			neg_q <= sum_q[SUM_W-1];
			zero_q <= (ccnt_q == '0);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			iter_q <= iter_q + ITER_W'(1);
		end
		if (cmd.avg_en) begin
			if (zero_q) begin
				avg_q <= '0;
			end else begin
				avg_q <= neg_q ? -$signed(quo_mag) : $signed(quo_mag);
			end
		end
		if (cmd.mul_en) begin
			prod_q <= avg_q * $signed({1'b0, cfg.threshold_multiplier});
		end
	end

	// Status and result generation.
	always_comb begin
		sts.calibrated = cal_q;
		sts.div_last = (iter_q == ITER_W'(DIV_STEPS - 1));
		push = (cmd.sample_en && is_det && in_last) || cmd.fix_en;
		if (cmd.fix_en) begin
			push_data.result_kind = RES_THR;
			push_data.above_threshold = 1'b0;
			push_data.loud_count = '0;
			push_data.average_level = avg_q;
			push_data.threshold_value = thr_new;
		end else begin
			push_data.result_kind = RES_VERDICT;
			push_data.above_threshold = (dcnt_next > cfg.count_limit);
			push_data.loud_count = dcnt_next;
			push_data.average_level = '0;
			push_data.threshold_value = thr_q;
		end
	end

endmodule

// ===== rtl/cstd_rq.sv =====
// Two-entry result queue that drives the result channel.
module cstd_rq (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cstd_pkg::result_t push_data,
	output logic full,
	cstd_report_if.source report
);
	import cstd_pkg::*;

	result_t ent_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic pop;
	result_t head;

	assign pop = report.valid && report.ready;
	assign full = (cnt_q == 2'd2);
	assign head = ent_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Channel outputs come from the head entry.
	assign report.valid = (cnt_q != '0);
	assign report.result_kind = head.result_kind;
	assign report.above_threshold = head.above_threshold;
	assign report.loud_count = head.loud_count;
	assign report.average_level = head.average_level;
	assign report.threshold_value = head.threshold_value;

endmodule

// ===== rtl/calibrated_sound_threshold_detector_unit.sv =====
// Calibrated sound threshold detector top level: registers, controller, datapath, result queue.
//
// Calibration and detection samples are taken one per clock cycle while no
// fix-threshold sequence runs and the result queue is not full; each one is
// folded into the running sum or the loud sample count in the cycle it is
// accepted, and a detection buffer's verdict is queued in that same cycle. A
// fix-threshold command that is carried out occupies the block: a restoring
// divider (one quotient bit per cycle) forms the average, then states ST_AVG,
// ST_MUL and ST_FIX sign the average, multiply it and clamp the threshold; input
// ready stays low meanwhile. A repeated command is accepted and produces nothing.
// Results wait in a two-entry queue; input is also held off while it is full.
// Configuration registers sit on APB at byte offset 4 times the register index.
module calibrated_sound_threshold_detector_unit #(
	parameter int BUFFER_SAMPLES = 1024
) (
	input logic clk,
	input logic arst_n,
	cstd_audio_if.sink audio,
	cstd_report_if.source report,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [cstd_pkg::ADDR_W-1:0] paddr,
	input logic [cstd_pkg::DATA_W-1:0] pwdata,
	output logic [cstd_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import cstd_pkg::*;

	cfg_t cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic in_ready;
	logic rq_full;
	logic push;
	result_t push_data;

	assign audio.ready = in_ready;

	// Configuration registers.
	cstd_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// Sequencing of items and the threshold computation.
	cstd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(audio.valid),
		.in_kind(audio.kind),
		.rq_full(rq_full),
		.sts(sts),
		.in_ready(in_ready),
		.cmd(cmd)
	);

	// Arithmetic and buffer state.
	cstd_dp #(
		.BUFFER_SAMPLES(BUFFER_SAMPLES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.in_kind(audio.kind),
		.in_sample(audio.sample),
		.in_last(audio.last_in_buffer),
		.sts(sts),
		.push(push),
		.push_data(push_data)
	);

	// Result queue.
	cstd_rq u_rq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(rq_full),
		.report(report)
	);

endmodule
